// ----- hw/rtl/ldu_fsa_pkg.sv -----
// shared types, codes and constants for the ldu face scatter accumulate block
`default_nettype none
package ldu_fsa_pkg;

   localparam int unsigned DEF_CELL_COUNT = 1024;
   localparam int unsigned DEF_FRAC_BITS  = 16;

   localparam int unsigned CMD_W   = 2;
   localparam int unsigned CELL_W  = 10;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned MODE_W  = 3;
   localparam int unsigned IDX_W   = 17;

   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FACE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

   localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SUB   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MAG   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ROW   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SPAI0 = 3'd4;
   localparam logic [MODE_W-1:0] MODE_NEGOD = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_LOAD_RD,
      ST_LOAD_WR,
      ST_LO_RD,
      ST_LO_WR,
      ST_HI_RD,
      ST_HI_WR,
      ST_RD,
      ST_CHK,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic take;
      logic side;
      logic mem_rd;
      logic load_wr;
      logic face_wr;
      logic div_start;
      logic div_step;
      logic emit;
   } ctl_type;

   typedef struct packed {
      logic             req_valid;
      logic [CMD_W-1:0] cmd;
      logic             in_range;
      logic             spai0;
      logic             diag_zero;
      logic             div_done;
      logic             rsp_free;
   } sts_type;

endpackage
`default_nettype wire

// ----- hw/rtl/ldu_fsa_if.sv -----
// request and response channel interfaces
`default_nettype none
interface ldu_fsa_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [ldu_fsa_pkg::CMD_W-1:0]        cmd;
   logic [ldu_fsa_pkg::CELL_W-1:0]       low_cell;
   logic [ldu_fsa_pkg::CELL_W-1:0]       high_cell;
   logic signed [ldu_fsa_pkg::DATA_W-1:0] cell_value;
   logic signed [ldu_fsa_pkg::DATA_W-1:0] lower_coeff;
   logic signed [ldu_fsa_pkg::DATA_W-1:0] upper_coeff;
   modport source (output valid, cmd, low_cell, high_cell, cell_value, lower_coeff,
                   upper_coeff, input ready);
   modport sink (input valid, cmd, low_cell, high_cell, cell_value, lower_coeff,
                 upper_coeff, output ready);
endinterface

interface ldu_fsa_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ldu_fsa_pkg::DATA_W-1:0] cell_result;
   logic                                 div_fault;
   logic                                 sat_flag;
   modport source (output valid, cell_result, div_fault, sat_flag, input ready);
   modport sink (input valid, cell_result, div_fault, sat_flag, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ldu_face_scatter_accumulate.sv -----
// top level: ldu face scatter accumulate, controller plus datapath
// one item at a time; the next item is taken only once the previous one has finished
// a read result is registered through the read, check and emit states; a mode 4 read with a nonzero
// diagonal also passes through the one-bit-per-cycle restoring divider
// the result register lets the next item enter while a result waits
// synchronous reset clears controller, mode, divider count and result valid; cell memories are not reset
`default_nettype none
module ldu_face_scatter_accumulate #(
   parameter int unsigned CELL_COUNT = ldu_fsa_pkg::DEF_CELL_COUNT,
   parameter int unsigned FRAC_BITS  = ldu_fsa_pkg::DEF_FRAC_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [ldu_fsa_pkg::MODE_W-1:0] csr_wr_data,
   ldu_fsa_req_if.sink                         req_bus,
   ldu_fsa_rsp_if.source                       rsp_bus
);

   ldu_fsa_pkg::ctl_type ctl;
   ldu_fsa_pkg::sts_type sts;

   ldu_fsa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .ctl   (ctl)
   );

   ldu_fsa_datapath #(
      .CELL_COUNT (CELL_COUNT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .ctl         (ctl),
      .sts         (sts)
   );

endmodule
`default_nettype wire

// ----- hw/rtl/ldu_fsa_ctrl.sv -----
// controller state machine sequencing loads, faces, reads and the divider
`default_nettype none
module ldu_fsa_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ldu_fsa_pkg::sts_type sts,
   output ldu_fsa_pkg::ctl_type      ctl
);

   ldu_fsa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ldu_fsa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         ldu_fsa_pkg::ST_IDLE: begin
            ctl.take = 1'b1;
            if (sts.req_valid) begin
               state_in = ldu_fsa_pkg::ST_DISPATCH;
            end
         end
         ldu_fsa_pkg::ST_DISPATCH: begin
            case (sts.cmd)
               ldu_fsa_pkg::CMD_LOAD: state_in = ldu_fsa_pkg::ST_LOAD_RD;
               ldu_fsa_pkg::CMD_FACE: state_in = ldu_fsa_pkg::ST_LO_RD;
               ldu_fsa_pkg::CMD_READ: state_in = ldu_fsa_pkg::ST_RD;
               default:               state_in = ldu_fsa_pkg::ST_IDLE;
            endcase
         end
         ldu_fsa_pkg::ST_LOAD_RD: begin
            ctl.mem_rd = 1'b1;
            state_in   = sts.in_range ? ldu_fsa_pkg::ST_LOAD_WR : ldu_fsa_pkg::ST_IDLE;
         end
         ldu_fsa_pkg::ST_LOAD_WR: begin
            ctl.load_wr = 1'b1;
            state_in    = ldu_fsa_pkg::ST_IDLE;
         end
         ldu_fsa_pkg::ST_LO_RD: begin
            ctl.mem_rd = 1'b1;
            state_in   = sts.in_range ? ldu_fsa_pkg::ST_LO_WR : ldu_fsa_pkg::ST_HI_RD;
         end
         ldu_fsa_pkg::ST_LO_WR: begin
            ctl.face_wr = 1'b1;
            state_in    = ldu_fsa_pkg::ST_HI_RD;
         end
         ldu_fsa_pkg::ST_HI_RD: begin
            ctl.side   = 1'b1;
            ctl.mem_rd = 1'b1;
            state_in   = sts.in_range ? ldu_fsa_pkg::ST_HI_WR : ldu_fsa_pkg::ST_IDLE;
         end
         ldu_fsa_pkg::ST_HI_WR: begin
            ctl.side    = 1'b1;
            ctl.face_wr = 1'b1;
            state_in    = ldu_fsa_pkg::ST_IDLE;
         end
         ldu_fsa_pkg::ST_RD: begin
            ctl.mem_rd = 1'b1;
            state_in   = ldu_fsa_pkg::ST_CHK;
         end
         ldu_fsa_pkg::ST_CHK: begin
            if (sts.in_range && sts.spai0 && !sts.diag_zero) begin
               ctl.div_start = 1'b1;
               state_in      = ldu_fsa_pkg::ST_DIV;
            end else begin
               state_in = ldu_fsa_pkg::ST_EMIT;
            end
         end
         ldu_fsa_pkg::ST_DIV: begin
            if (sts.div_done) begin
               state_in = ldu_fsa_pkg::ST_EMIT;
            end else begin
               ctl.div_step = 1'b1;
            end
         end
         ldu_fsa_pkg::ST_EMIT: begin
            if (sts.rsp_free) begin
               ctl.emit = 1'b1;
               state_in = ldu_fsa_pkg::ST_IDLE;
            end
         end
         default: state_in = ldu_fsa_pkg::ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ----- hw/rtl/ldu_fsa_datapath.sv -----
// datapath: item registers, cell memories, squarer, divider and result register
`default_nettype none
module ldu_fsa_datapath #(
   parameter int unsigned CELL_COUNT = ldu_fsa_pkg::DEF_CELL_COUNT,
   parameter int unsigned FRAC_BITS  = ldu_fsa_pkg::DEF_FRAC_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [ldu_fsa_pkg::MODE_W-1:0]    csr_wr_data,
   ldu_fsa_req_if.sink                            req_bus,
   ldu_fsa_rsp_if.source                          rsp_bus,
   input  wire ldu_fsa_pkg::ctl_type              ctl,
   output ldu_fsa_pkg::sts_type                   sts
);

   localparam int unsigned AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int unsigned DW = ldu_fsa_pkg::DATA_W;
   localparam int unsigned NW = DW + FRAC_BITS;
   localparam int unsigned CW = $clog2(NW + 1);
   localparam int unsigned IW = ldu_fsa_pkg::IDX_W;

   logic [ldu_fsa_pkg::MODE_W-1:0] mode_ff;
   logic [ldu_fsa_pkg::CMD_W-1:0]  cmd_ff;
   logic [ldu_fsa_pkg::CELL_W-1:0] lo_ff, hi_ff;
   logic signed [DW-1:0]           val_ff, lc_ff, uc_ff;

   logic [DW:0]                    accum_mem [CELL_COUNT];
   logic [DW-1:0]                  diag_mem  [CELL_COUNT];
   logic [DW:0]                    rd_ff;
   logic signed [DW-1:0]           diag_rd_ff;
   logic [2*DW-1:0]                prod_ff;

   logic [DW-1:0]                  rem_ff, den_ff;
   logic [NW-1:0]                  quo_ff;
   logic [CW-1:0]                  cnt_ff;
   logic                           neg_ff;

   logic                           rsp_valid_ff, rsp_fault_ff, rsp_sat_ff;
   logic signed [DW-1:0]           rsp_res_ff;

   logic [IW-1:0]                  idx_ext;
   logic [AW-1:0]                  addr;
   logic                           in_range;
   logic signed [DW-1:0]           op;
   logic [DW-1:0]                  op_mag;
   logic [2*DW-1:0]                prod_sh;
   logic [DW:0]                    sq;
   logic signed [DW+1:0]           op_ext, term, sum;
   logic signed [DW-1:0]           acc, sum_cl, load_val;
   logic                           sum_sat, load_sat;
   logic [DW-1:0]                  acc_mag, den_mag;
   logic [DW:0]                    rem_sh;
   logic                           ge;
   logic                           spai0;
   logic signed [DW-1:0]           q_val, res_val;
   logic                           q_sat, res_fault, res_sat;

   assign spai0   = (mode_ff == ldu_fsa_pkg::MODE_SPAI0);
   assign idx_ext = ctl.side ? IW'(hi_ff) : IW'(lo_ff);
   assign addr    = idx_ext[AW-1:0];
   assign in_range = (idx_ext < IW'(CELL_COUNT));

   assign op      = (cmd_ff == ldu_fsa_pkg::CMD_LOAD) ? val_ff : (ctl.side ? uc_ff : lc_ff);
   assign op_mag  = op[DW-1] ? DW'(-op) : DW'(op);
   assign op_ext  = (DW+2)'(op);
   assign prod_sh = prod_ff >> FRAC_BITS;
   assign sq      = (prod_sh > (2*DW)'(32'h7FFFFFFF)) ? {2'b01, {(DW-1){1'b0}}}
                                                       : prod_sh[DW:0];
   assign acc     = $signed(rd_ff[DW-1:0]);

   always_comb begin
      case (mode_ff)
         ldu_fsa_pkg::MODE_SUB, ldu_fsa_pkg::MODE_NEGOD: term = -op_ext;
         ldu_fsa_pkg::MODE_MAG:   term = op[DW-1] ? -op_ext : op_ext;
         ldu_fsa_pkg::MODE_SPAI0: term = $signed({1'b0, sq});
         default:                 term = op_ext;
      endcase
      sum = (DW+2)'(acc) + term;
      sum_sat = 1'b0;
      sum_cl  = sum[DW-1:0];
      if (sum > (DW+2)'(32'sh7FFFFFFF)) begin
         sum_sat = 1'b1;
         sum_cl  = 32'sh7FFFFFFF;
      end else if (sum < -(DW+2)'(33'sh080000000)) begin
         sum_sat = 1'b1;
         sum_cl  = 32'sh80000000;
      end
      load_sat = 1'b0;
      case (mode_ff)
         ldu_fsa_pkg::MODE_SPAI0: begin
            load_sat = sq[DW-1];
            load_val = sq[DW-1] ? 32'sh7FFFFFFF : $signed(sq[DW-1:0]);
         end
         ldu_fsa_pkg::MODE_NEGOD: load_val = '0;
         default:                 load_val = val_ff;
      endcase
   end

   assign acc_mag = acc[DW-1] ? DW'(-acc) : DW'(acc);
   assign den_mag = diag_rd_ff[DW-1] ? DW'(-diag_rd_ff) : DW'(diag_rd_ff);
   assign rem_sh  = {rem_ff, quo_ff[NW-1]};
   assign ge      = (rem_sh >= {1'b0, den_ff});

   always_comb begin
      q_sat = 1'b0;
      q_val = neg_ff ? $signed(-quo_ff[DW-1:0]) : $signed(quo_ff[DW-1:0]);
      if (!neg_ff && quo_ff > NW'(32'h7FFFFFFF)) begin
         q_sat = 1'b1;
         q_val = 32'sh7FFFFFFF;
      end else if (neg_ff && quo_ff > NW'(32'h80000000)) begin
         q_sat = 1'b1;
         q_val = 32'sh80000000;
      end
      res_val   = '0;
      res_fault = 1'b0;
      res_sat   = 1'b0;
      if (in_range) begin
         res_sat = rd_ff[DW];
         if (spai0) begin
            if (diag_rd_ff == '0) begin
               res_fault = 1'b1;
            end else begin
               res_val = q_val;
               res_sat = rd_ff[DW] | q_sat;
            end
         end else begin
            res_val = acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ldu_fsa_pkg::MODE_ADD;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && ctl.take) begin
         cmd_ff <= req_bus.cmd;
         lo_ff  <= req_bus.low_cell;
         hi_ff  <= req_bus.high_cell;
         val_ff <= req_bus.cell_value;
         lc_ff  <= req_bus.lower_coeff;
         uc_ff  <= req_bus.upper_coeff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mem_rd) begin
         rd_ff      <= accum_mem[addr];
         diag_rd_ff <= diag_mem[addr];
         prod_ff    <= op_mag * op_mag;
      end
      if (ctl.load_wr) begin
         accum_mem[addr] <= {load_sat, load_val};
         diag_mem[addr]  <= val_ff;
      end else if (ctl.face_wr) begin
         accum_mem[addr] <= {rd_ff[DW] | sum_sat, sum_cl};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (ctl.div_start) begin
         cnt_ff <= CW'(NW);
      end else if (ctl.div_step) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.div_start) begin
         rem_ff <= '0;
         quo_ff <= NW'(acc_mag) << FRAC_BITS;
         den_ff <= den_mag;
         neg_ff <= acc[DW-1] ^ diag_rd_ff[DW-1];
      end else if (ctl.div_step) begin
         rem_ff <= ge ? DW'(rem_sh - {1'b0, den_ff}) : rem_sh[DW-1:0];
         quo_ff <= {quo_ff[NW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_res_ff   <= res_val;
         rsp_fault_ff <= res_fault;
         rsp_sat_ff   <= res_sat;
      end
   end

   assign req_bus.ready       = ctl.take;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.cell_result = rsp_res_ff;
   assign rsp_bus.div_fault   = rsp_fault_ff;
   assign rsp_bus.sat_flag    = rsp_sat_ff;

   assign sts.req_valid = req_bus.valid;
   assign sts.cmd       = cmd_ff;
   assign sts.in_range  = in_range;
   assign sts.spai0     = spai0;
   assign sts.diag_zero = (diag_rd_ff == '0);
   assign sts.div_done  = (cnt_ff == '0);
   assign sts.rsp_free  = !rsp_valid_ff || rsp_bus.ready;

endmodule
`default_nettype wire

// ----- tb/ldu_face_scatter_accumulate_tb.sv -----
// testbench for the ldu face scatter accumulate block: directed table, then random phases per mode
`timescale 1ns / 100ps
module ldu_face_scatter_accumulate_tb;
   import ldu_fsa_pkg::*;

   localparam int unsigned NCELL   = 1024;
   localparam int unsigned FRACB   = 16;
   localparam int unsigned STALL_LIMIT = 20000;
   localparam int unsigned QUIET_CYCLES = 120;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic [CELL_W-1:0]        low_cell;
      logic [CELL_W-1:0]        high_cell;
      logic signed [DATA_W-1:0] cell_value;
      logic signed [DATA_W-1:0] lower_coeff;
      logic signed [DATA_W-1:0] upper_coeff;
   } req_item_t;

   typedef struct packed {
      logic signed [DATA_W-1:0] cell_result;
      logic                     div_fault;
      logic                     sat_flag;
   } rsp_item_t;

   typedef struct {
      logic [MODE_W-1:0] mode;
      req_item_t         item;
      logic              typed;
      rsp_item_t         want;
   } dir_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [MODE_W-1:0] csr_wr_data = '0;

   ldu_fsa_req_if req_bus();
   ldu_fsa_rsp_if rsp_bus();

   ldu_face_scatter_accumulate u_dut (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic signed [DATA_W-1:0] cell_sum [NCELL];
   logic signed [DATA_W-1:0] cell_diag [NCELL];
   logic                     cell_sat [NCELL];
   bit                       cell_loaded [NCELL];
   logic [MODE_W-1:0]        cur_mode;

   rsp_item_t pending_rsp [$];
   int unsigned fail_count = 0;
   int unsigned reads_done = 0;
   int unsigned items_sent = 0;
   int unsigned idle_cycles = 0;
   bit          calm = 1'b0;
   bit          timed_out = 1'b0;

   function automatic logic signed [DATA_W-1:0] clamp_fx(longint v, inout logic sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic longint square_q(longint v);
      longint unsigned m;
      longint unsigned p;
      m = (v < 0) ? -v : v;
      p = (m * m) >> FRACB;
      if (p > 64'd2147483647) return 64'sd2147483648;
      return p;
   endfunction

   function automatic void scatter_coeff(logic [CELL_W-1:0] c, logic signed [DATA_W-1:0] k);
      longint term;
      logic    s;
      if (c >= NCELL) return;
      s = 1'b0;
      case (cur_mode)
         MODE_SUB, MODE_NEGOD: term = -longint'(k);
         MODE_MAG: term = (k < 0) ? -longint'(k) : longint'(k);
         MODE_SPAI0: term = square_q(k);
         default: term = k;
      endcase
      cell_sum[c] = clamp_fx(longint'(cell_sum[c]) + term, s);
      if (s) cell_sat[c] = 1'b1;
   endfunction

   function automatic void apply_item(req_item_t it);
      rsp_item_t r;
      logic s;
      longint num;
      s = 1'b0;
      case (it.cmd)
         CMD_LOAD: if (it.low_cell < NCELL) begin
            cell_diag[it.low_cell] = it.cell_value;
            if (cur_mode == MODE_SPAI0)
               cell_sum[it.low_cell] = clamp_fx(square_q(it.cell_value), s);
            else if (cur_mode == MODE_NEGOD) cell_sum[it.low_cell] = '0;
            else cell_sum[it.low_cell] = it.cell_value;
            cell_sat[it.low_cell] = s;
            cell_loaded[it.low_cell] = 1'b1;
         end
         CMD_FACE: begin
            scatter_coeff(it.low_cell, it.lower_coeff);
            scatter_coeff(it.high_cell, it.upper_coeff);
         end
         CMD_READ: begin
            r = '0;
            if (it.low_cell < NCELL) begin
               s = cell_sat[it.low_cell];
               if (cur_mode == MODE_SPAI0) begin
                  if (cell_diag[it.low_cell] == 0) r.div_fault = 1'b1;
                  else begin
                     num = longint'(cell_sum[it.low_cell]) <<< FRACB;
                     r.cell_result = clamp_fx(num / longint'(cell_diag[it.low_cell]), s);
                  end
               end else r.cell_result = cell_sum[it.low_cell];
            end
            r.sat_flag = s;
            pending_rsp.push_back(r);
         end
         default: ;
      endcase
   endfunction

   task automatic idle_gap();
      if (!calm && $urandom_range(99) < 7) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_item(req_item_t it);
      idle_gap();
      req_bus.valid <= 1'b1;
      {req_bus.cmd, req_bus.low_cell, req_bus.high_cell, req_bus.cell_value,
       req_bus.lower_coeff, req_bus.upper_coeff} <= it;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      apply_item(it);
      items_sent++;
   endtask

   task automatic drain_and_set_mode(logic [MODE_W-1:0] m);
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_mode = (m > MODE_NEGOD) ? MODE_ADD : m;
   endtask

   function automatic logic signed [DATA_W-1:0] rand_value();
      case ($urandom_range(5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 32'sh0;
         3: return $signed(32'($urandom_range(0, 32'h3ffff))) - 32'sh20000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CELL_W-1:0] rand_loaded_cell();
      logic [CELL_W-1:0] c;
      c = CELL_W'($urandom_range(0, 63));
      if (!cell_loaded[c]) c = 0;
      return c;
   endfunction

   function automatic req_item_t make_item(logic [CMD_W-1:0] cmd, int lo, int hi,
                                           logic signed [DATA_W-1:0] v,
                                           logic signed [DATA_W-1:0] a,
                                           logic signed [DATA_W-1:0] b);
      req_item_t it;
      it.cmd = cmd; it.low_cell = CELL_W'(lo); it.high_cell = CELL_W'(hi);
      it.cell_value = v; it.lower_coeff = a; it.upper_coeff = b;
      return it;
   endfunction

   // response side: random stalls and in-order compare
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= calm || ($urandom_range(99) >= 7);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected item result=%h", $time, rsp_bus.cell_result);
               fail_count++;
            end else begin
               if ({rsp_bus.cell_result, rsp_bus.div_fault, rsp_bus.sat_flag}
                   !== pending_rsp[0]) begin
                  $display("%0t: mismatch expected res=%h div=%b sat=%b actual res=%h div=%b sat=%b",
                           $time, pending_rsp[0].cell_result, pending_rsp[0].div_fault,
                           pending_rsp[0].sat_flag, rsp_bus.cell_result,
                           rsp_bus.div_fault, rsp_bus.sat_flag);
                  fail_count++;
               end
               void'(pending_rsp.pop_front());
               reads_done++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || pending_rsp.size() == 0 && !req_bus.valid)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      dir_row_t dir_rows [$];
      dir_row_t row;
      req_item_t it;
      int kind;

      req_bus.valid = 1'b0;
      {req_bus.cmd, req_bus.low_cell, req_bus.high_cell, req_bus.cell_value,
       req_bus.lower_coeff, req_bus.upper_coeff} = '0;
      cur_mode = MODE_ADD;
      for (int i = 0; i < NCELL; i++) begin
         cell_sum[i] = '0; cell_diag[i] = '0; cell_sat[i] = 1'b0; cell_loaded[i] = 1'b0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      row.typed = 1'b0; row.want = '0; row.mode = MODE_ADD;
      row.item = make_item(CMD_LOAD, 0, 0, 32'sh7fffffff, 0, 0); dir_rows.push_back(row);
      row.item = make_item(CMD_LOAD, 1023, 0, 32'sh80000000, 0, 0); dir_rows.push_back(row);
      row.item = make_item(CMD_READ, 0, 0, 0, 0, 0);
      row.typed = 1'b1; row.want = '{32'sh7fffffff, 1'b0, 1'b0}; dir_rows.push_back(row);
      row.item = make_item(CMD_FACE, 0, 1023, 0, 32'sh1, -32'sh1);
      row.typed = 1'b0; dir_rows.push_back(row);
      row.item = make_item(CMD_READ, 1023, 0, 0, 0, 0);
      row.typed = 1'b1; row.want = '{32'sh80000000, 1'b0, 1'b1}; dir_rows.push_back(row);
      row.item = make_item(CMD_READ, 0, 0, 0, 0, 0);
      row.want = '{32'sh7fffffff, 1'b0, 1'b1}; dir_rows.push_back(row);
      row.item = make_item(CMD_UNUSED, 5, 6, 32'sh1234, 1, 1);
      row.typed = 1'b0; dir_rows.push_back(row);
      row.item = make_item(CMD_LOAD, 7, 0, 32'sh10000, 0, 0); dir_rows.push_back(row);
      row.item = make_item(CMD_FACE, 7, 7, 0, 32'sh20000, 32'sh30000); dir_rows.push_back(row);
      row.item = make_item(CMD_READ, 7, 0, 0, 0, 0);
      row.typed = 1'b1; row.want = '{32'sh60000, 1'b0, 1'b0}; dir_rows.push_back(row);
      row.mode = MODE_SPAI0; row.typed = 1'b0;
      row.item = make_item(CMD_LOAD, 3, 0, 32'sh0, 0, 0); dir_rows.push_back(row);
      row.item = make_item(CMD_READ, 3, 0, 0, 0, 0);
      row.typed = 1'b1; row.want = '{32'sh0, 1'b1, 1'b0}; dir_rows.push_back(row);
      row.item = make_item(CMD_LOAD, 4, 0, 32'sh80000000, 0, 0);
      row.typed = 1'b0; dir_rows.push_back(row);
      row.item = make_item(CMD_READ, 4, 0, 0, 0, 0); dir_rows.push_back(row);
      row.item = make_item(CMD_LOAD, 5, 0, 32'sh20000, 0, 0); dir_rows.push_back(row);
      row.item = make_item(CMD_FACE, 5, 1023, 0, 32'shfffe0000, 32'sh7fffffff);
      dir_rows.push_back(row);
      row.item = make_item(CMD_READ, 5, 0, 0, 0, 0); dir_rows.push_back(row);
      row.item = make_item(CMD_READ, 1023, 0, 0, 0, 0); dir_rows.push_back(row);
      row.mode = MODE_SUB;
      row.item = make_item(CMD_LOAD, 8, 0, 32'sh80000000, 0, 0); dir_rows.push_back(row);
      row.item = make_item(CMD_FACE, 8, 7, 0, 32'sh1, 32'sh2); dir_rows.push_back(row);
      row.item = make_item(CMD_READ, 8, 0, 0, 0, 0);
      row.typed = 1'b1; row.want = '{32'sh80000000, 1'b0, 1'b1}; dir_rows.push_back(row);
      row.mode = MODE_NEGOD; row.typed = 1'b0;
      row.item = make_item(CMD_LOAD, 8, 0, 32'sh7fffffff, 0, 0); dir_rows.push_back(row);
      row.item = make_item(CMD_FACE, 8, 8, 0, 32'sh5, 32'sh80000000); dir_rows.push_back(row);
      row.item = make_item(CMD_READ, 8, 0, 0, 0, 0); dir_rows.push_back(row);
      row.item = make_item(CMD_READ, 1023, 0, 0, 0, 0); dir_rows.push_back(row);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].mode != cur_mode || i == 0) drain_and_set_mode(dir_rows[i].mode);
         send_item(dir_rows[i].item);
         if (dir_rows[i].typed) begin
            if (pending_rsp.size() == 0 || pending_rsp[$] !== dir_rows[i].want) begin
               $display("%0t: table row %0d expected %h actual %h", $time, i,
                        dir_rows[i].want, pending_rsp[$]);
               fail_count++;
            end
         end
      end

      // random phases over every mode value
      for (int ph = 0; ph < 10; ph++) begin
         drain_and_set_mode((ph < 8) ? ph[2:0] : MODE_W'($urandom_range(0, 7)));
         calm = (ph == 3);
         for (int c = 0; c < 64; c++)
            send_item(make_item(CMD_LOAD, c, $urandom, rand_value(), $urandom, $urandom));
         for (int n = 0; n < 130; n++) begin
            kind = $urandom_range(99);
            if (kind < 50)
               it = make_item(CMD_FACE, rand_loaded_cell(), rand_loaded_cell(), $urandom,
                              rand_value(), rand_value());
            else if (kind < 80)
               it = make_item(CMD_READ, rand_loaded_cell(), $urandom, $urandom,
                              $urandom, $urandom);
            else if (kind < 88)
               it = make_item(CMD_LOAD, rand_loaded_cell(), $urandom, rand_value(),
                              $urandom, $urandom);
            else if (kind < 94)
               it = make_item(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
               it = make_item(CMD_READ, $urandom_range(NCELL, 1023) | 10'h200,
                              $urandom, $urandom, $urandom, $urandom);
            if (it.low_cell >= 64 && it.cmd == CMD_READ && it.low_cell < NCELL)
               it.low_cell = 0;
            send_item(it);
         end
         calm = 1'b0;
      end

      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      $display("items sent %0d, reads checked %0d, all eight mode values written",
               items_sent, reads_done);
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
